@@ hw/rtl/mfek_pkg.sv @@
// shared constants and types for the max flow block
package mfek_pkg;
    localparam int NODES = 16;
    localparam int CAP_W = 16;
    localparam int RES_W = 18;
    localparam int FLOW_W = 20;
    localparam logic [CAP_W-1:0] CAP_MAX = 16'hFFFF;
    localparam logic [FLOW_W-1:0] FLOW_MAX = 20'hFFFFF;
    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_SINK = 1'b1;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_LOAD_WR, CMD_CLR, CMD_BFS_INIT, CMD_BFS_POP,
        CMD_BFS_CHK, CMD_TR_RD, CMD_TR_CHK, CMD_UP_RD, CMD_UP_SUB, CMD_UP_ADD,
        CMD_FLOW_ADD, CMD_DONE
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic q_empty;
        logic row_done;
        logic found;
        logic at_src;
        logic bad_cfg;
    } stat_t;
endpackage

@@ hw/rtl/mfek_datapath.sv @@
// residual memory, search queue, parent table and flow accumulator
module mfek_datapath import mfek_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    input  logic [3:0]       src,
    input  logic [3:0]       dst,
    input  logic [3:0]       ld_from,
    input  logic [3:0]       ld_to,
    input  logic [CAP_W-1:0] ld_cap,
    output stat_t            stat,
    output logic [FLOW_W-1:0] flow
);
    localparam int NW = $clog2(NODES);
    localparam int AW = 2 * NW;
    logic [RES_W-1:0] mem [NODES*NODES];
    logic [RES_W-1:0] rd_reg;
    logic [AW-1:0] clr_reg;
    logic [NW-1:0] parent_reg [NODES];
    logic [NW-1:0] queue_reg [NODES];
    logic [NODES-1:0] vis_reg;
    logic [NW:0] head_reg, tail_reg;
    logic [NW-1:0] u_reg, v_reg, pv_reg;
    logic [RES_W-1:0] bot_reg;
    logic [FLOW_W-1:0] flow_reg;
    logic [3:0] lf_reg, lt_reg;
    logic [CAP_W-1:0] lc_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [RES_W-1:0] wr_data;
    logic wr_en;
    logic [RES_W:0] ld_sum;
    logic [NW-1:0] s_n, t_n;
    logic [FLOW_W:0] fsum;

    assign s_n = src[NW-1:0];
    assign t_n = dst[NW-1:0];
    assign stat.bad_cfg = (32'(src) >= NODES) || (32'(dst) >= NODES) || (src == dst);
    assign stat.clr_done = (clr_reg == AW'(NODES*NODES-1));
    assign stat.q_empty = (head_reg >= tail_reg);
    assign stat.row_done = (32'(v_reg) == NODES - 1);
    // sink reached by the neighbor under test
    assign stat.found = !vis_reg[v_reg] && (rd_reg != '0) && (v_reg == t_n);
    assign stat.at_src = (v_reg == s_n);
    assign flow = flow_reg;
    assign ld_sum = {1'b0, rd_reg} + (RES_W+1)'(lc_reg);
    assign fsum = {1'b0, flow_reg} + (FLOW_W+1)'(bot_reg);

    always_comb begin
        rd_addr = '0;
        case (cmd)
            CMD_BFS_POP: rd_addr = {queue_reg[head_reg[NW-1:0]], {NW{1'b0}}};
            CMD_BFS_CHK: rd_addr = {u_reg, v_reg + NW'(1)};
            CMD_TR_RD:   rd_addr = {parent_reg[v_reg], v_reg};
            CMD_UP_RD:   rd_addr = {parent_reg[v_reg], v_reg};
            CMD_UP_SUB:  rd_addr = {v_reg, pv_reg};
            default:     rd_addr = {ld_from[NW-1:0], ld_to[NW-1:0]};
        endcase
        wr_en = 1'b0;
        wr_addr = {lf_reg[NW-1:0], lt_reg[NW-1:0]};
        wr_data = (ld_sum > (RES_W+1)'(CAP_MAX)) ? RES_W'(CAP_MAX) : ld_sum[RES_W-1:0];
        case (cmd)
            CMD_LOAD_WR: wr_en = (32'(lf_reg) < NODES) && (32'(lt_reg) < NODES);
            CMD_CLR: begin
                wr_en = 1'b1; wr_addr = clr_reg; wr_data = '0;
            end
            CMD_UP_SUB: begin
                wr_en = 1'b1; wr_addr = {pv_reg, v_reg}; wr_data = rd_reg - bot_reg;
            end
            CMD_UP_ADD: begin
                wr_en = 1'b1; wr_addr = {v_reg, pv_reg}; wr_data = rd_reg + bot_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_reg <= mem[rd_addr];
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0; flow_reg <= '0; vis_reg <= '0;
            head_reg <= '0; tail_reg <= '0;
        end else begin
            case (cmd)
                CMD_CLR: clr_reg <= clr_reg + AW'(1);
                CMD_LOAD: begin
                    lf_reg <= ld_from; lt_reg <= ld_to; lc_reg <= ld_cap;
                end
                CMD_BFS_INIT: begin
                    vis_reg <= NODES'(1) << s_n;
                    parent_reg[s_n] <= s_n; queue_reg[0] <= s_n;
                    head_reg <= '0; tail_reg <= (NW+1)'(1);
                    bot_reg <= '1;
                end
                CMD_BFS_POP: begin
                    u_reg <= queue_reg[head_reg[NW-1:0]];
                    head_reg <= head_reg + (NW+1)'(1);
                    v_reg <= '0;
                end
                CMD_BFS_CHK: begin
                    if (!vis_reg[v_reg] && rd_reg != '0) begin
                        vis_reg[v_reg] <= 1'b1;
                        parent_reg[v_reg] <= u_reg;
                        if (32'(tail_reg) < NODES) begin
                            queue_reg[tail_reg[NW-1:0]] <= v_reg;
                            tail_reg <= tail_reg + (NW+1)'(1);
                        end
                    end
                    if (stat.found)
                        v_reg <= t_n;
                    else
                        v_reg <= v_reg + NW'(1);
                end
                CMD_FLOW_ADD: begin
                    flow_reg <= (fsum > (FLOW_W+1)'(FLOW_MAX)) ? FLOW_MAX : fsum[FLOW_W-1:0];
                    v_reg <= t_n;
                end
                CMD_TR_CHK: begin
                    if (rd_reg < bot_reg) bot_reg <= rd_reg;
                    v_reg <= parent_reg[v_reg];
                end
                CMD_UP_RD: pv_reg <= parent_reg[v_reg];
                CMD_UP_ADD: v_reg <= pv_reg;
                CMD_DONE: begin
                    flow_reg <= '0; clr_reg <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule

@@ hw/rtl/mfek_ctrl.sv @@
// sequencer for load, search, path update and clear
module mfek_ctrl import mfek_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_xfer,
    input  logic  in_last,
    input  logic  out_busy,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  in_ready,
    output logic  res_valid,
    output logic  res_err,
    input  logic  out_taken
);
    typedef enum logic [3:0] {
        S_CLR, S_LOAD, S_LWR, S_INIT, S_POP, S_CHK, S_TRD, S_TCHK,
        S_URD, S_USUB, S_UADD, S_EMIT, S_FLOW
    } state_t;
    state_t state_reg;
    logic err_reg, last_reg;

    assign in_ready = (state_reg == S_LOAD) && !out_busy;
    assign res_valid = (state_reg == S_EMIT);
    assign res_err = err_reg;

    always_comb begin
        case (state_reg)
            S_CLR:   cmd = CMD_CLR;
            S_LOAD:  cmd = in_xfer ? CMD_LOAD : CMD_NONE;
            S_LWR:   cmd = CMD_LOAD_WR;
            S_INIT:  cmd = CMD_BFS_INIT;
            S_POP:   cmd = stat.q_empty ? CMD_NONE : CMD_BFS_POP;
            S_CHK:   cmd = CMD_BFS_CHK;
            S_TRD:   cmd = CMD_TR_RD;
            S_TCHK:  cmd = CMD_TR_CHK;
            S_URD:   cmd = CMD_UP_RD;
            S_USUB:  cmd = CMD_UP_SUB;
            S_UADD:  cmd = CMD_UP_ADD;
            S_FLOW:  cmd = CMD_FLOW_ADD;
            S_EMIT:  cmd = out_taken ? CMD_DONE : CMD_NONE;
            default: cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR; err_reg <= 1'b0; last_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_CLR: if (stat.clr_done) state_reg <= S_LOAD;
                S_LOAD: if (in_xfer) begin
                    last_reg <= in_last;
                    state_reg <= S_LWR;
                end
                // edge written back; the last one starts the search, or flags a bad source/sink setting
                S_LWR: begin
                    if (last_reg) begin
                        err_reg <= stat.bad_cfg;
                        state_reg <= stat.bad_cfg ? S_EMIT : S_INIT;
                    end else begin
                        state_reg <= S_LOAD;
                    end
                end
                S_INIT: state_reg <= S_POP;
                // pop next node; an empty queue means no path is left
                S_POP: state_reg <= stat.q_empty ? S_EMIT : S_CHK;
                S_CHK: begin
                    if (stat.found) state_reg <= S_TRD;
                    else if (stat.row_done) state_reg <= S_POP;
                end
                S_TRD: state_reg <= stat.at_src ? S_FLOW : S_TCHK;
                S_TCHK: state_reg <= S_TRD;
                S_FLOW: state_reg <= S_URD;
                S_URD: state_reg <= stat.at_src ? S_INIT : S_USUB;
                S_USUB: state_reg <= S_UADD;
                S_UADD: state_reg <= S_URD;
                S_EMIT: if (out_taken) state_reg <= S_CLR;
                default: state_reg <= S_CLR;
            endcase
        end
    end
endmodule

@@ hw/rtl/max_flow_edmonds_karp.sv @@
// max flow block top level: stream ports, controller and datapath
// edge loads: each transfer is accepted with a read, then written back before the next is taken
// search: an init step, then per dequeued node a pop followed by a check of each neighbour in turn
// each path found: trace back from the sink for the bottleneck, flow add, then update of both directions per hop
// result held until its transfer completes, then a clear pass over all NODES*NODES entries
// reset: synchronous active-low aresetn, source 0, sink 15, store cleared
module max_flow_edmonds_karp import mfek_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // from_node, to_node, capacity
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // max_flow
    output logic        m_tuser   // error
);
    logic [3:0] src_reg, dst_reg;
    cmd_t cmd;
    stat_t stat;
    logic in_ready, res_valid, res_err, in_xfer;
    logic [FLOW_W-1:0] flow;

    assign in_xfer = s_tvalid && s_tready;
    assign s_tready = in_ready;
    assign m_tvalid = res_valid;
    assign m_tdata = {4'b0, res_err ? {FLOW_W{1'b0}} : flow};
    assign m_tuser = res_err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg <= 4'd0; dst_reg <= 4'd15;
        end else if (cfg_we) begin
            if (cfg_index == REG_SOURCE) src_reg <= cfg_data;
            else dst_reg <= cfg_data;
        end
    end

    mfek_ctrl u_ctrl (
        .aclk, .aresetn, .in_xfer, .in_last(s_tlast), .out_busy(1'b0), .stat, .cmd,
        .in_ready, .res_valid, .res_err, .out_taken(m_tvalid && m_tready)
    );

    mfek_datapath u_dp (
        .aclk, .aresetn, .cmd, .src(src_reg), .dst(dst_reg),
        .ld_from(s_tdata[3:0]), .ld_to(s_tdata[7:4]), .ld_cap(s_tdata[23:8]),
        .stat, .flow
    );

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[19:0] == '0) else $error("err flow");
    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("overlap");
endmodule

@@ tb/sv/tb.sv @@
// testbench for the max flow block: edge-load stimulus, flow predictor, result checks
`timescale 1ns / 1ps
module tb;
    import mfek_pkg::*;

    localparam int N = 16;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int SETTLE_CYCLES = 400;
    localparam logic [RES_W-1:0] RES_MASK = '1;

    typedef struct {
        logic [3:0]  from_node;
        logic [3:0]  to_node;
        logic [15:0] capacity;
        logic        last;
    } load_t;

    typedef struct {
        logic [FLOW_W-1:0] max_flow;
        logic              error;
    } flow_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [3:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;

    max_flow_edmonds_karp uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    load_t        pending_loads[$];
    flow_result_t expected_flows[$];
    logic [RES_W-1:0] residual[N][N];
    logic [3:0]   src_node, snk_node;
    int           mismatches;
    int           cycles;
    int           sender_idle_pct, receiver_idle_pct;
    int           rx_hold;
    int           loads_queued;
    logic         s_fire;

    initial begin
        aclk = 0;
    end
    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // breadth-first augmenting paths, lowest neighbour first
    function automatic flow_result_t compute_max_flow(logic [3:0] s, logic [3:0] t);
        flow_result_t r;
        logic [N-1:0] seen;
        logic [3:0] parent[N];
        logic [3:0] bfs_q[N];
        int head, tail, u, v, total;
        logic [RES_W-1:0] neck;
        bit found;
        r.max_flow = '0;
        r.error = (s == t);
        total = 0;
        if (!r.error) begin
            forever begin
                seen = '0;
                head = 0;
                tail = 0;
                found = 0;
                bfs_q[tail++] = s;
                seen[s] = 1;
                parent[s] = s;
                while (head < tail && !found) begin
                    u = bfs_q[head++];
                    for (v = 0; v < N && !found; v++) begin
                        if (!seen[v] && residual[u][v] > 0) begin
                            parent[v] = 4'(u);
                            seen[v] = 1;
                            if (tail < N) bfs_q[tail++] = 4'(v);
                            if (v == t) found = 1;
                        end
                    end
                end
                if (!found) break;
                neck = RES_MASK;
                v = t;
                while (v != s) begin
                    u = parent[v];
                    if (residual[u][v] < neck) neck = residual[u][v];
                    v = u;
                end
                v = t;
                while (v != s) begin
                    u = parent[v];
                    residual[u][v] = residual[u][v] - neck;
                    residual[v][u] = residual[v][u] + neck;
                    v = u;
                end
                total += neck;
                if (total > FLOW_MAX) total = FLOW_MAX;
            end
            r.max_flow = FLOW_W'(total);
        end
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
                residual[i][j] = '0;
        return r;
    endfunction

    // prediction on input transfers, checking on result transfers
    always @(posedge aclk) begin
        load_t ld;
        int sum;
        flow_result_t want;
        cycles++;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            ld.from_node = s_tdata[3:0];
            ld.to_node = s_tdata[7:4];
            ld.capacity = s_tdata[23:8];
            ld.last = s_tlast;
            sum = residual[ld.from_node][ld.to_node] + ld.capacity;
            residual[ld.from_node][ld.to_node] = (sum > CAP_MAX) ? RES_W'(CAP_MAX) : RES_W'(sum);
            if (ld.last) expected_flows.push_back(compute_max_flow(src_node, snk_node));
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_flows.size() == 0) begin
                report("unexpected result", m_tdata[19:0], -1);
            end else begin
                want = expected_flows.pop_front();
                if (m_tdata[19:0] !== want.max_flow) report("max_flow", m_tdata[19:0], want.max_flow);
                if (m_tuser !== want.error) report("error", m_tuser, want.error);
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // edge driver
    always @(negedge aclk) begin
        load_t ld;
        if (!aresetn) begin
            s_tvalid <= 0;
        end else if (!s_tvalid || s_fire) begin
            if (pending_loads.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                ld = pending_loads.pop_front();
                s_tvalid <= 1;
                s_tdata <= {ld.capacity, ld.to_node, ld.from_node};
                s_tlast <= ld.last;
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // result receiver, with a long hold-off when requested
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic queue_load(int f, int t, int c, bit l);
        load_t ld;
        ld.from_node = 4'(f);
        ld.to_node = 4'(t);
        ld.capacity = 16'(c);
        ld.last = l;
        pending_loads.push_back(ld);
        loads_queued++;
    endtask

    // wait until every load is sent and every result is back, then let the clear pass finish
    task automatic settle();
        while (pending_loads.size() > 0 || s_tvalid || expected_flows.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(logic idx, logic [3:0] val);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 0;
        if (idx == REG_SOURCE) src_node = val;
        else snk_node = val;
    endtask

    function automatic int pick_node();
        int k;
        k = $urandom_range(9);
        if (k < 2) return src_node;
        if (k < 4) return snk_node;
        if (k < 8) return $urandom_range(5);
        return $urandom_range(15);
    endfunction

    function automatic int pick_cap();
        case ($urandom_range(7))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(65535);
            3: return $urandom_range(65535, 60000);
            default: return $urandom_range(200);
        endcase
    endfunction

    task automatic queue_graph();
        int n;
        n = $urandom_range(24, 2);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0)
                queue_load($urandom_range(15), $urandom_range(15), $urandom, i == n - 1);
            else
                queue_load(pick_node(), pick_node(), pick_cap(), i == n - 1);
        end
    endtask

    task automatic random_cfg();
        case ($urandom_range(5))
            0: begin write_cfg(REG_SOURCE, 0); write_cfg(REG_SINK, 15); end
            1: begin write_cfg(REG_SOURCE, 15); write_cfg(REG_SINK, 0); end
            2: begin write_cfg(REG_SOURCE, 7); write_cfg(REG_SINK, 7); end
            default: begin
                write_cfg(REG_SOURCE, 4'($urandom_range(15)));
                write_cfg(REG_SINK, 4'($urandom_range(15)));
            end
        endcase
    endtask

    task automatic random_part(int target);
        int graphs;
        graphs = 0;
        while (loads_queued < target) begin
            queue_graph();
            graphs++;
            if (graphs % 6 == 0) begin
                settle();
                random_cfg();
            end
        end
        settle();
    endtask

    initial begin
        mismatches = 0;
        cycles = 0;
        loads_queued = 0;
        rx_hold = 0;
        sender_idle_pct = 31;
        receiver_idle_pct = 49;
        aresetn = 0;
        cfg_we = 0;
        cfg_index = REG_SOURCE;
        cfg_data = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        m_tready = 0;
        s_fire = 0;
        src_node = 0;
        snk_node = 15;
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
                residual[i][j] = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        // directed: single edge at full and zero capacity, saturating reload,
        // self-loop beside a real path, edge only in the reverse direction, two paths with a cross edge
        queue_load(0, 15, 65535, 1);
        queue_load(0, 15, 0, 1);
        queue_load(0, 15, 65535, 0);
        queue_load(0, 15, 65535, 1);
        queue_load(0, 0, 5, 0);
        queue_load(0, 1, 7, 0);
        queue_load(1, 15, 3, 0);
        queue_load(1, 1, 65535, 1);
        queue_load(15, 0, 9, 1);
        queue_load(0, 1, 10, 0);
        queue_load(0, 2, 10, 0);
        queue_load(1, 2, 4, 0);
        queue_load(2, 15, 12, 0);
        queue_load(1, 15, 3, 1);
        settle();
        write_cfg(REG_SOURCE, 5);
        write_cfg(REG_SINK, 5);
        queue_load(5, 6, 100, 0);
        queue_load(6, 5, 100, 1);
        settle();
        write_cfg(REG_SOURCE, 15);
        write_cfg(REG_SINK, 0);
        queue_load(15, 0, 65535, 0);
        queue_load(15, 3, 65535, 0);
        queue_load(3, 0, 40000, 1);
        settle();

        random_part(400);

        // receiver stalls long while several graphs are offered
        rx_hold = 6000;
        for (int i = 0; i < 4; i++) queue_graph();
        settle();

        sender_idle_pct = 49;
        receiver_idle_pct = 31;
        random_part(800);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        random_part(1200);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
